// ----- rtl/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared sizes, codes, types and helper functions of the multilevel
// feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic OP_ARRIVE   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic {
        CMD_ARRIVE,
        CMD_DISPATCH
    } cmd_kind_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  task_id;
        logic [15:0] burst_time;
        logic [31:0] start_time;
    } cmd_t;

    // One entry of the task store.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] left;
        logic [31:0] start;
    } task_t;

    localparam int TASK_W = $bits(task_t);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                    input logic [PTR_W-1:0] p);
        int a;
        a = int'(lv) * QUEUE_DEPTH + int'(p);
        return ADDR_W'(a);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mlfq_ram.sv -----
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/mlfq_front.sv -----
// ----------------------------------------------------------------------------
// mlfq_front
// Accepts input words, decodes the opcode and holds the classified
// commands in a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          opcode,
    input  wire logic [7:0]    task_id,
    input  wire logic [15:0]   burst_time,
    input  wire logic [31:0]   start_time,
    output logic               cmd_valid,
    output mlfq_pkg::cmd_t     cmd,
    input  wire logic          cmd_pop
);

    mlfq_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;

    mlfq_pkg::cmd_t decoded;
    logic           push;
    logic           pop;

    always_comb
    begin
        decoded.task_id    = task_id;
        decoded.burst_time = burst_time;
        decoded.start_time = start_time;
        unique case (opcode)
            mlfq_pkg::OP_ARRIVE:   decoded.kind = mlfq_pkg::CMD_ARRIVE;
            mlfq_pkg::OP_DISPATCH: decoded.kind = mlfq_pkg::CMD_DISPATCH;
            default:               decoded.kind = mlfq_pkg::CMD_ARRIVE;
        endcase
    end

    assign in_stall  = (fill_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlfq_back.sv -----
// ----------------------------------------------------------------------------
// mlfq_back
// Executes arrive and dispatch commands against the level queues, keeps
// the virtual clock and the switch count, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire mlfq_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         status,
    output logic [7:0]         ran_id,
    output logic [2:0]         ran_level,
    output logic               finished,
    output logic [15:0]        time_left,
    output logic [31:0]        finish_time,
    output logic [31:0]        turnaround,
    output logic [31:0]        switch_count
);

    localparam int LEVELS = mlfq_pkg::LEVELS;
    localparam int LVL_W  = mlfq_pkg::LVL_W;
    localparam int PTR_W  = mlfq_pkg::PTR_W;
    localparam int CNT_W  = mlfq_pkg::CNT_W;
    localparam int ADDR_W = mlfq_pkg::ADDR_W;
    localparam int TASK_W = mlfq_pkg::TASK_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg [LEVELS];
    logic [CNT_W-1:0]   count_next [LEVELS];
    logic [PTR_W-1:0]   head_reg [LEVELS];
    logic [PTR_W-1:0]   head_next [LEVELS];
    logic [PTR_W-1:0]   tail_reg [LEVELS];
    logic [PTR_W-1:0]   tail_next [LEVELS];
    logic [LVL_W-1:0]   lv_reg, lv_next;
    logic [31:0]        clock_reg, clock_next;
    logic [31:0]        switches_reg, switches_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         ran_id_reg, ran_id_next;
    logic [2:0]         ran_level_reg, ran_level_next;
    logic               finished_reg, finished_next;
    logic [15:0]        time_left_reg, time_left_next;
    logic [31:0]        finish_time_reg, finish_time_next;
    logic [31:0]        turnaround_reg, turnaround_next;
    logic [31:0]        switch_count_reg, switch_count_next;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    mlfq_pkg::task_t    ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [TASK_W-1:0]  ram_rd_raw;
    mlfq_pkg::task_t    popped;

    logic               all_empty;
    logic [LVL_W-1:0]   sel_lv;
    logic               out_free;
    logic [31:0]        quantum;
    logic [31:0]        clock_after;
    logic [LVL_W-1:0]   next_lv;
    logic [LVL_W-1:0]   dest_lv;

    mlfq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (mlfq_pkg::SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign popped = mlfq_pkg::task_t'(ram_rd_raw);

    // Highest-priority non-empty level; lower index wins.
    always_comb
    begin
        all_empty = 1'b1;
        sel_lv    = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                all_empty = 1'b0;
                sel_lv    = LVL_W'(i);
            end
        end
    end

    // The result register frees up in the same cycle it is taken.
    assign out_free = !out_valid_reg || !out_stall;

    assign quantum     = 32'd2 << lv_reg;
    assign clock_after = clock_reg + quantum;
    assign next_lv     = lv_reg + 1'b1;

    always_comb
    begin
        if ((lv_reg != LVL_W'(LEVELS - 1))
            && (count_reg[next_lv] != CNT_W'(mlfq_pkg::QUEUE_DEPTH)))
            dest_lv = next_lv;
        else
            dest_lv = lv_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        lv_next           = lv_reg;
        clock_next        = clock_reg;
        switches_next     = switches_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        ran_id_next       = ran_id_reg;
        ran_level_next    = ran_level_reg;
        finished_next     = finished_reg;
        time_left_next    = time_left_reg;
        finish_time_next  = finish_time_reg;
        turnaround_next   = turnaround_reg;
        switch_count_next = switch_count_reg;
        cmd_pop           = 1'b0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = '0;
        ram_wr_data       = '0;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == mlfq_pkg::CMD_DISPATCH && !all_empty)
                    begin
                        // Pop the head now; the entry comes out of memory next cycle.
                        ram_rd_en           = 1'b1;
                        ram_rd_addr         = mlfq_pkg::slot_addr(sel_lv, head_reg[sel_lv]);
                        head_next[sel_lv]   = mlfq_pkg::ptr_inc(head_reg[sel_lv]);
                        count_next[sel_lv]  = count_reg[sel_lv] - 1'b1;
                        lv_next             = sel_lv;
                        state_next          = S_EXEC;
                    end
                    else
                    begin
                        status_next = mlfq_pkg::ST_OK;
                        if (cmd.kind == mlfq_pkg::CMD_DISPATCH)
                        begin
                            status_next = mlfq_pkg::ST_EMPTY;
                        end
                        else if (count_reg[0] == CNT_W'(mlfq_pkg::QUEUE_DEPTH))
                        begin
                            status_next = mlfq_pkg::ST_FULL;
                        end
                        else
                        begin
                            if (all_empty && (cmd.start_time > clock_reg))
                            begin
                                clock_next = cmd.start_time;
                            end
                            ram_wr_en         = 1'b1;
                            ram_wr_addr       = mlfq_pkg::slot_addr('0, tail_reg[0]);
                            ram_wr_data.id    = cmd.task_id;
                            ram_wr_data.left  = cmd.burst_time;
                            ram_wr_data.start = cmd.start_time;
                            tail_next[0]      = mlfq_pkg::ptr_inc(tail_reg[0]);
                            count_next[0]     = count_reg[0] + 1'b1;
                        end
                        out_valid_next    = 1'b1;
                        ran_id_next       = '0;
                        ran_level_next    = '0;
                        finished_next     = 1'b0;
                        time_left_next    = '0;
                        finish_time_next  = clock_next;
                        turnaround_next   = '0;
                        switch_count_next = switches_reg;
                    end
                end
            end

            S_EXEC:
            begin
                clock_next        = clock_after;
                out_valid_next    = 1'b1;
                status_next       = mlfq_pkg::ST_OK;
                ran_id_next       = popped.id;
                ran_level_next    = 3'(lv_reg);
                finish_time_next  = clock_after;
                if ({16'd0, popped.left} <= quantum)
                begin
                    finished_next     = 1'b1;
                    time_left_next    = '0;
                    turnaround_next   = clock_after - popped.start;
                    switch_count_next = switches_reg;
                end
                else
                begin
                    finished_next     = 1'b0;
                    time_left_next    = popped.left - quantum[15:0];
                    turnaround_next   = '0;
                    if (switches_reg != '1)
                    begin
                        switches_next = switches_reg + 32'd1;
                    end
                    switch_count_next  = switches_next;
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = mlfq_pkg::slot_addr(dest_lv, tail_reg[dest_lv]);
                    ram_wr_data.id     = popped.id;
                    ram_wr_data.left   = time_left_next;
                    ram_wr_data.start  = popped.start;
                    tail_next[dest_lv] = mlfq_pkg::ptr_inc(tail_reg[dest_lv]);
                    count_next[dest_lv] = count_reg[dest_lv] + 1'b1;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            for (int i = 0; i < LEVELS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
            end
            lv_reg           <= '0;
            clock_reg        <= '0;
            switches_reg     <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            ran_id_reg       <= '0;
            ran_level_reg    <= '0;
            finished_reg     <= 1'b0;
            time_left_reg    <= '0;
            finish_time_reg  <= '0;
            turnaround_reg   <= '0;
            switch_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            lv_reg           <= lv_next;
            clock_reg        <= clock_next;
            switches_reg     <= switches_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            ran_id_reg       <= ran_id_next;
            ran_level_reg    <= ran_level_next;
            finished_reg     <= finished_next;
            time_left_reg    <= time_left_next;
            finish_time_reg  <= finish_time_next;
            turnaround_reg   <= turnaround_next;
            switch_count_reg <= switch_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign ran_id       = ran_id_reg;
    assign ran_level    = ran_level_reg;
    assign finished     = finished_reg;
    assign time_left    = time_left_reg;
    assign finish_time  = finish_time_reg;
    assign turnaround   = turnaround_reg;
    assign switch_count = switch_count_reg;

endmodule

`default_nettype wire

// ----- rtl/multilevel_feedback_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue scheduler: a front end that takes and decodes
// words, a two-entry command queue, and a back end that runs the queues.
// ----------------------------------------------------------------------------
// Each input word yields exactly one result word. An arrive, a rejected
// arrive and an empty dispatch are done in S_IDLE of the back end; a
// dispatch that runs a task goes through S_IDLE and S_EXEC: its entry is
// read from the synchronous task memory in S_IDLE and the updated task is
// written back to its new level in S_EXEC. The front end buffers up to two
// words, so until both are held the input side keeps moving while the back
// end works or a finished result waits in the output register. The task
// memory needs no clearing after reset: only queued entries are ever read.
`default_nettype none

module multilevel_feedback_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] burst_time,
    input  wire logic [31:0] start_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       ran_id,
    output logic [2:0]       ran_level,
    output logic             finished,
    output logic [15:0]      time_left,
    output logic [31:0]      finish_time,
    output logic [31:0]      turnaround,
    output logic [31:0]      switch_count
);

    logic           cmd_valid;
    logic           cmd_pop;
    mlfq_pkg::cmd_t cmd;

    mlfq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .task_id    (task_id),
        .burst_time (burst_time),
        .start_time (start_time),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    mlfq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .ran_id       (ran_id),
        .ran_level    (ran_level),
        .finished     (finished),
        .time_left    (time_left),
        .finish_time  (finish_time),
        .turnaround   (turnaround),
        .switch_count (switch_count)
    );

endmodule

`default_nettype wire
